/* hw/rtl/soc_pkg.sv */
// Shared types and constants for the substring occurrence counter.
package soc_pkg;

  localparam int PATTERN_BITS      = 64;
  localparam int LENGTH_BITS       = 4;
  localparam int TEXT_BITS         = 8;
  localparam int MATCH_COUNT_BITS  = 16;
  localparam int CFG_INDEX_BITS    = 1;

  localparam logic [CFG_INDEX_BITS-1:0] REG_PATTERN_BYTES  = 1'b0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_PATTERN_LENGTH = 1'b1;

  // Control for one step of the matcher.
  typedef struct packed {
    logic go;
    logic last;
  } step_t;

endpackage

/* hw/rtl/soc_match.sv */
// Shift-and matcher with the running occurrence total for one string.
module soc_match #(
  parameter int MAX_PATTERN_BYTES = 8,
  parameter int COUNT_BITS        = 16
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  soc_pkg::step_t                         step,
  input  logic [soc_pkg::TEXT_BITS-1:0]          text_byte,
  input  logic [soc_pkg::PATTERN_BITS-1:0]       pattern_bytes,
  input  logic [soc_pkg::LENGTH_BITS-1:0]        pattern_length,
  output logic [soc_pkg::MATCH_COUNT_BITS-1:0]   count_value
);

  localparam int WIDE_BITS = COUNT_BITS + soc_pkg::MATCH_COUNT_BITS;

  logic [MAX_PATTERN_BYTES-1:0] vec;
  logic [MAX_PATTERN_BYTES-1:0] vec_next;
  logic [COUNT_BITS-1:0]        total;
  logic [COUNT_BITS-1:0]        total_next;
  logic [MAX_PATTERN_BYTES-1:0] eq;
  logic [MAX_PATTERN_BYTES-1:0] sel;
  logic [MAX_PATTERN_BYTES-1:0] shifted;
  logic [soc_pkg::LENGTH_BITS-1:0] len;
  logic [WIDE_BITS-1:0]         wide;
  logic                         hit;

  always_comb begin
    if (pattern_length > soc_pkg::LENGTH_BITS'(MAX_PATTERN_BYTES)) begin
      len = soc_pkg::LENGTH_BITS'(MAX_PATTERN_BYTES);
    end else begin
      len = pattern_length;
    end
    for (int k = 0; k < MAX_PATTERN_BYTES; k++) begin
      eq[k]  = (soc_pkg::LENGTH_BITS'(k) < len) &&
               (pattern_bytes[8*k +: 8] == text_byte);
      sel[k] = (len == soc_pkg::LENGTH_BITS'(k + 1));
    end
    shifted = (vec << 1) | MAX_PATTERN_BYTES'(1);
  end

  // shifted holds the prefix set moved up one byte with a fresh start at bit 0
  always_comb begin
    vec_next = shifted & eq;
    hit      = |(vec_next & sel);
    total_next = total;
    if (hit) begin
      vec_next = '0;
      if (total != '1) begin
        total_next = total + COUNT_BITS'(1);
      end
    end
    wide = WIDE_BITS'(total_next);
    if (wide > WIDE_BITS'({soc_pkg::MATCH_COUNT_BITS{1'b1}})) begin
      count_value = '1;
    end else begin
      count_value = wide[soc_pkg::MATCH_COUNT_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vec   <= '0;
      total <= '0;
    end else if (step.go) begin
      if (step.last) begin
        vec   <= '0;
        total <= '0;
      end else begin
        vec   <= vec_next;
        total <= total_next;
      end
    end
  end

`ifndef SYNTHESIS
  a_clear_on_hit: assert property (@(posedge clk) disable iff (rst)
    (step.go && hit) |=> (vec == '0))
    else $error("prefix vector not cleared after a match");

  a_clear_on_last: assert property (@(posedge clk) disable iff (rst)
    (step.go && step.last) |=> (total == '0))
    else $error("total not cleared at end of string");
`endif

endmodule

/* hw/rtl/substring_occurrence_counter.sv */
// Top level of the substring occurrence counter.
//
// Counts non-overlapping, leftmost-first occurrences of a 1 to 8 byte pattern
// in a byte stream. Text bytes come in on text_valid/text_stall with
// end_of_text marking the final byte of a string; the count leaves on
// count_valid/count_stall as match_count, one transfer per string.
// The pattern is set through cfg_valid/cfg_ready (always ready): index 0 is
// pattern_bytes, index 1 is pattern_length (low four bits of cfg_data).
// Write the registers only while no string is in flight.
// One text byte is taken per cycle while text_stall is low. Bytes go through
// an input register and the shift-and update; a string's count is loaded into
// match_count when its last byte leaves the input register. While count_stall
// holds a pending count, bytes without the end mark still advance; a last
// byte waits in the input register and text_stall rises. Reset (rst,
// synchronous) clears the pattern, the matcher state and both valid flags.
module substring_occurrence_counter #(
  parameter int MAX_PATTERN_BYTES = 8,
  parameter int COUNT_BITS        = 16
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   text_valid,
  output logic                                   text_stall,
  input  logic [soc_pkg::TEXT_BITS-1:0]          text_byte,
  input  logic                                   end_of_text,
  output logic                                   count_valid,
  input  logic                                   count_stall,
  output logic [soc_pkg::MATCH_COUNT_BITS-1:0]   match_count,
  input  logic                                   cfg_valid,
  output logic                                   cfg_ready,
  input  logic [soc_pkg::CFG_INDEX_BITS-1:0]     cfg_index,
  input  logic [soc_pkg::PATTERN_BITS-1:0]       cfg_data
);

  logic [soc_pkg::PATTERN_BITS-1:0]     pattern_bytes;
  logic [soc_pkg::LENGTH_BITS-1:0]      pattern_length;
  logic                                 s1_valid;
  logic [soc_pkg::TEXT_BITS-1:0]        s1_byte;
  logic                                 s1_last;
  logic                                 out_free;
  logic                                 s1_go;
  logic                                 text_take;
  soc_pkg::step_t                       step;
  logic [soc_pkg::MATCH_COUNT_BITS-1:0] count_value;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      pattern_bytes  <= '0;
      pattern_length <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        soc_pkg::REG_PATTERN_BYTES:  pattern_bytes  <= cfg_data;
        soc_pkg::REG_PATTERN_LENGTH: pattern_length <= cfg_data[soc_pkg::LENGTH_BITS-1:0];
        default: ;
      endcase
    end
  end

  assign out_free   = !count_valid || !count_stall;
  assign s1_go      = s1_valid && (!s1_last || out_free);
  assign text_stall = s1_valid && !s1_go;
  assign text_take  = text_valid && !text_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (text_take) begin
      s1_valid <= 1'b1;
    end else if (s1_go) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (text_take) begin
      s1_byte <= text_byte;
      s1_last <= end_of_text;
    end
  end

  assign step.go   = s1_go;
  assign step.last = s1_last;

  soc_match #(
    .MAX_PATTERN_BYTES(MAX_PATTERN_BYTES),
    .COUNT_BITS       (COUNT_BITS)
  ) u_match (
    .clk           (clk),
    .rst           (rst),
    .step          (step),
    .text_byte     (s1_byte),
    .pattern_bytes (pattern_bytes),
    .pattern_length(pattern_length),
    .count_value   (count_value)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      count_valid <= 1'b0;
    end else if (s1_go && s1_last) begin
      count_valid <= 1'b1;
    end else if (!count_stall) begin
      count_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go && s1_last) begin
      match_count <= count_value;
    end
  end

`ifndef SYNTHESIS
  a_last_gives_count: assert property (@(posedge clk) disable iff (rst)
    (s1_go && s1_last) |=> count_valid)
    else $error("end of string did not load a count");

  a_stall_only_when_full: assert property (@(posedge clk) disable iff (rst)
    text_stall |-> (s1_valid && s1_last && count_valid && count_stall))
    else $error("input stalled without a blocked last byte");

  a_no_count_overwrite: assert property (@(posedge clk) disable iff (rst)
    (count_valid && count_stall) |-> !(s1_go && s1_last))
    else $error("pending count overwritten");
`endif

endmodule
